>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/ctdu_pkg.sv
// ----------------------------------------------------------------------------
// ctdu_pkg
// Widths, codes and pipeline depths of the cube map texel to direction unit.
// ----------------------------------------------------------------------------
package ctdu_pkg;

  localparam int COORD_BITS = 14;
  localparam int FRAC_BITS  = 14;
  localparam int SIZE_W     = COORD_BITS + 1;
  localparam int OUT_W      = 16;
  localparam int FACE_W     = 3;
  localparam int CFG_IDX_W  = 1;

  localparam int MAG_W  = FRAC_BITS + 1;
  localparam int CN_W   = SIZE_W + FRAC_BITS + 2;
  localparam int SQ_W   = 2 * FRAC_BITS + 1;
  localparam int SUM_W  = SQ_W + 1;
  localparam int QSH    = 2 * FRAC_BITS + 2;
  localparam int NUM_W  = SQ_W + QSH;
  localparam int QUO_W  = QSH + 1;
  localparam int ROOT_W = (QUO_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 4;

  localparam int COORD_LAT = FRAC_BITS + 2;
  localparam int LANE_LAT  = QUO_W + ROOT_W + 2;

  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACE_WIDTH  = 1'b0,
    REG_FACE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic zero;
    logic neg_a;
    logic neg_b;
    logic neg_c;
  } sign_meta_t;

endpackage

>>> hw/rtl/ctdu_if.sv
// ----------------------------------------------------------------------------
// ctdu_in_if / ctdu_out_if
// Valid/ready channels for texel addresses and direction vectors.
// ----------------------------------------------------------------------------
interface ctdu_in_if;
  import ctdu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] texel_col;
  logic [COORD_BITS-1:0] texel_row;
  logic [FACE_W-1:0]     face_index;
  modport source (output valid, texel_col, texel_row, face_index, input ready);
  modport sink   (input valid, texel_col, texel_row, face_index, output ready);
endinterface

interface ctdu_out_if;
  import ctdu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] dir_x;
  logic signed [OUT_W-1:0] dir_y;
  logic signed [OUT_W-1:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

>>> hw/rtl/ctdu_coord_div.sv
// ----------------------------------------------------------------------------
// ctdu_coord_div
// Pipelined rounding divider that maps a texel center to a face coordinate.
// ----------------------------------------------------------------------------
module ctdu_coord_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ctdu_pkg::COORD_BITS-1:0] pos,
  input  logic [ctdu_pkg::SIZE_W-1:0]     size,
  output logic [ctdu_pkg::MAG_W-1:0]      mag_o,
  output logic                            neg_o
);
  import ctdu_pkg::*;

  logic [SIZE_W-1:0] twice;
  logic              neg;
  logic [SIZE_W-1:0] mag;
  logic [CN_W-1:0]   num;
  logic [SIZE_W:0]   dv;

  logic [CN_W-1:0]  rem_r [0:FRAC_BITS];
  logic [SIZE_W:0]  div_r [0:FRAC_BITS];
  logic [MAG_W-1:0] quo_r [0:FRAC_BITS+1];
  logic             sat_r [0:FRAC_BITS+1];
  logic             neg_r [0:FRAC_BITS+1];

  logic [CN_W-1:0] dsh [0:FRAC_BITS];
  logic            ge  [0:FRAC_BITS];

  always_comb begin
    twice = {pos, 1'b1};
    neg   = twice < size;
    mag   = neg ? size - twice : twice - size;
    num   = (CN_W'(mag) << (FRAC_BITS + 1)) + CN_W'(size);
    dv    = {size, 1'b0};
    for (int k = 0; k <= FRAC_BITS; k++) begin
      dsh[k] = CN_W'(div_r[k]) << (FRAC_BITS - k);
      ge[k]  = rem_r[k] >= dsh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      div_r[0] <= dv;
      quo_r[0] <= '0;
      sat_r[0] <= num >= ((CN_W'(dv) << FRAC_BITS) + CN_W'(dv));
      neg_r[0] <= neg;
      for (int k = 0; k < FRAC_BITS; k++) begin
        rem_r[k+1] <= ge[k] ? rem_r[k] - dsh[k] : rem_r[k];
        div_r[k+1] <= div_r[k];
      end
      for (int k = 0; k <= FRAC_BITS; k++) begin
        quo_r[k+1] <= {quo_r[k][MAG_W-2:0], ge[k]};
        sat_r[k+1] <= sat_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  assign mag_o = sat_r[FRAC_BITS+1] ? ONE_MAG : quo_r[FRAC_BITS+1];
  assign neg_o = neg_r[FRAC_BITS+1];

endmodule

>>> hw/rtl/ctdu_norm_lane.sv
// ----------------------------------------------------------------------------
// ctdu_norm_lane
// One normalized component: a pipelined divider of the squared component by
// the squared length, then a pipelined integer square root with rounding.
// ----------------------------------------------------------------------------
module ctdu_norm_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ctdu_pkg::SQ_W-1:0]  sq,
  input  logic [ctdu_pkg::SUM_W-1:0] sum,
  output logic [ctdu_pkg::MAG_W-1:0] n_o
);
  import ctdu_pkg::*;

  logic [NUM_W-1:0]  nrem_r [0:QUO_W-1];
  logic [SUM_W-1:0]  nden_r [0:QUO_W-1];
  logic [QUO_W-1:0]  nquo_r [0:QUO_W];
  logic [NUM_W:0]    dsh    [0:QUO_W-1];
  logic              dge    [0:QUO_W-1];

  logic [RAD_W-1:0]  rad_r  [1:ROOT_W-1];
  logic [REM_W-1:0]  srem_r [1:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];
  logic [RAD_W-1:0]  rad_c  [0:ROOT_W-1];
  logic [REM_W-1:0]  srem_c [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_c [0:ROOT_W-1];
  logic [REM_W-1:0]  cur    [0:ROOT_W-1];
  logic [REM_W-1:0]  test   [0:ROOT_W-1];
  logic              sge    [0:ROOT_W-1];

  logic [ROOT_W:0]   rnd;
  logic [MAG_W-1:0]  n_r;

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      dsh[k] = (NUM_W + 1)'(nden_r[k]) << (QUO_W - 1 - k);
      dge[k] = {1'b0, nrem_r[k]} >= dsh[k];
    end
    rad_c[0]  = {1'b0, nquo_r[QUO_W]};
    srem_c[0] = '0;
    root_c[0] = '0;
    for (int j = 1; j < ROOT_W; j++) begin
      rad_c[j]  = rad_r[j];
      srem_c[j] = srem_r[j];
      root_c[j] = root_r[j];
    end
    for (int j = 0; j < ROOT_W; j++) begin
      cur[j]  = {srem_c[j][REM_W-3:0], rad_c[j][RAD_W-1:RAD_W-2]};
      test[j] = REM_W'({root_c[j], 2'b01});
      sge[j]  = cur[j] >= test[j];
    end
    rnd = (ROOT_W + 1)'(root_r[ROOT_W]) + (ROOT_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrem_r[0] <= NUM_W'(sq) << QSH;
      nden_r[0] <= sum;
      nquo_r[0] <= '0;
      for (int k = 0; k < QUO_W - 1; k++) begin
        nrem_r[k+1] <= dge[k] ? nrem_r[k] - dsh[k][NUM_W-1:0] : nrem_r[k];
        nden_r[k+1] <= nden_r[k];
      end
      for (int k = 0; k < QUO_W; k++) begin
        nquo_r[k+1] <= {nquo_r[k][QUO_W-2:0], dge[k]};
      end
      for (int j = 0; j < ROOT_W - 1; j++) begin
        rad_r[j+1]  <= rad_c[j] << 2;
        srem_r[j+1] <= sge[j] ? cur[j] - test[j] : cur[j];
      end
      for (int j = 0; j < ROOT_W; j++) begin
        root_r[j+1] <= {root_c[j][ROOT_W-2:0], sge[j]};
      end
      n_r <= rnd[MAG_W:1];
    end
  end

  assign n_o = n_r;

endmodule

>>> hw/rtl/cubemap_texel_to_direction_unit.sv
// ----------------------------------------------------------------------------
// cubemap_texel_to_direction_unit
// Maps a cube map texel address to the unit direction through its center.
// ----------------------------------------------------------------------------
// Use: a texel address (texel_col, texel_row, face_index) is offered on in_ch
// and the normalized direction (dir_x, dir_y, dir_z, Q2.14) comes back on
// out_ch, one result per transfer, in order. A face index above five gives
// the zero vector. face_width and face_height are written on the cfg port
// while the unit is idle; a zero value acts as one.
// One transfer is taken every cycle unless the receiver stalls: the work is
// split into a rounding divider of 16 stages per face coordinate, a squaring
// stage and three normalization lanes of 49 stages each (a one-bit-per-stage
// divider and a two-bit-per-stage square root), with valid bits traveling
// beside the data. When the receiver stalls, the whole pipeline holds and
// in_ch.ready drops while a finished result waits; nothing is lost or
// repeated. Reset clears all valid bits and sets both size registers to one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubemap_texel_to_direction_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  ctdu_in_if.sink                        in_ch,
  ctdu_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ctdu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctdu_pkg::SIZE_W-1:0]    cfg_data
);
  import ctdu_pkg::*;

  localparam int DOM_MIN = 9459;

  logic en;

  logic [SIZE_W-1:0] w_r, h_r;
  logic [SIZE_W-1:0] w_eff, h_eff;

  logic                  s0_v_r;
  logic [COORD_BITS-1:0] s0_col_r, s0_row_r;
  logic [SIZE_W-1:0]     s0_w_r, s0_h_r;
  logic [FACE_W-1:0]     s0_face_r;

  logic [MAG_W-1:0] u_mag, v_mag;
  logic             u_neg, row_neg;

  logic              fd_v_r    [0:COORD_LAT-1];
  logic [FACE_W-1:0] fd_face_r [0:COORD_LAT-1];

  logic [MAG_W-1:0] ma_nxt, mb_nxt, mc_nxt;
  sign_meta_t       pm_nxt;
  logic             p_v_r;
  logic [MAG_W-1:0] ma_r, mb_r, mc_r;
  sign_meta_t       pm_r;

  logic [SQ_W-1:0]  sqa_r, sqb_r, sqc_r;
  logic [SUM_W-1:0] sum;

  logic             md_v_r [0:LANE_LAT];
  sign_meta_t       md_r   [0:LANE_LAT];

  logic [MAG_W-1:0] na, nb, nc;

  logic                    out_valid_r;
  logic                    out_zero_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r, out_z_r;
  logic [OUT_W-1:0]        abs_x, abs_y, abs_z;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= SIZE_W'(1);
      h_r <= SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FACE_WIDTH:  w_r <= cfg_data;
        REG_FACE_HEIGHT: h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (w_r == '0) ? SIZE_W'(1) : w_r;
  assign h_eff = (h_r == '0) ? SIZE_W'(1) : h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_col_r  <= in_ch.texel_col;
      s0_row_r  <= in_ch.texel_row;
      s0_face_r <= in_ch.face_index;
      s0_w_r    <= w_eff;
      s0_h_r    <= h_eff;
    end
  end

  ctdu_coord_div u_coord_u (
    .clk   (clk),
    .en    (en),
    .pos   (s0_col_r),
    .size  (s0_w_r),
    .mag_o (u_mag),
    .neg_o (u_neg)
  );

  ctdu_coord_div u_coord_v (
    .clk   (clk),
    .en    (en),
    .pos   (s0_row_r),
    .size  (s0_h_r),
    .mag_o (v_mag),
    .neg_o (row_neg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < COORD_LAT; k++) fd_v_r[k] <= 1'b0;
    end else if (en) begin
      fd_v_r[0] <= s0_v_r;
      for (int k = 1; k < COORD_LAT; k++) fd_v_r[k] <= fd_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fd_face_r[0] <= s0_face_r;
      for (int k = 1; k < COORD_LAT; k++) fd_face_r[k] <= fd_face_r[k-1];
    end
  end

  // v is the negated row coordinate, so its sign is the inverse of row_neg.
  always_comb begin
    ma_nxt      = ONE_MAG;
    mb_nxt      = ONE_MAG;
    mc_nxt      = ONE_MAG;
    pm_nxt      = '0;
    unique case (face_t'(fd_face_r[COORD_LAT-1]))
      FACE_POS_X: begin
        mb_nxt = v_mag; pm_nxt.neg_b = !row_neg;
        mc_nxt = u_mag; pm_nxt.neg_c = !u_neg;
      end
      FACE_NEG_X: begin
        pm_nxt.neg_a = 1'b1;
        mb_nxt = v_mag; pm_nxt.neg_b = !row_neg;
        mc_nxt = u_mag; pm_nxt.neg_c = u_neg;
      end
      FACE_POS_Y: begin
        ma_nxt = u_mag; pm_nxt.neg_a = u_neg;
        mc_nxt = v_mag; pm_nxt.neg_c = row_neg;
      end
      FACE_NEG_Y: begin
        ma_nxt = u_mag; pm_nxt.neg_a = u_neg;
        pm_nxt.neg_b = 1'b1;
        mc_nxt = v_mag; pm_nxt.neg_c = !row_neg;
      end
      FACE_POS_Z: begin
        ma_nxt = u_mag; pm_nxt.neg_a = u_neg;
        mb_nxt = v_mag; pm_nxt.neg_b = !row_neg;
      end
      FACE_NEG_Z: begin
        ma_nxt = u_mag; pm_nxt.neg_a = !u_neg;
        mb_nxt = v_mag; pm_nxt.neg_b = !row_neg;
        pm_nxt.neg_c = 1'b1;
      end
      default: begin
        pm_nxt.zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= fd_v_r[COORD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      mc_r  <= mc_nxt;
      pm_r  <= pm_nxt;
      sqa_r <= SQ_W'(ma_r) * SQ_W'(ma_r);
      sqb_r <= SQ_W'(mb_r) * SQ_W'(mb_r);
      sqc_r <= SQ_W'(mc_r) * SQ_W'(mc_r);
    end
  end

  assign sum = SUM_W'(sqa_r) + SUM_W'(sqb_r) + SUM_W'(sqc_r);

  ctdu_norm_lane u_lane_a (.clk(clk), .en(en), .sq(sqa_r), .sum(sum), .n_o(na));
  ctdu_norm_lane u_lane_b (.clk(clk), .en(en), .sq(sqb_r), .sum(sum), .n_o(nb));
  ctdu_norm_lane u_lane_c (.clk(clk), .en(en), .sq(sqc_r), .sum(sum), .n_o(nc));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LANE_LAT; k++) md_v_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      md_v_r[0] <= p_v_r;
      for (int k = 1; k <= LANE_LAT; k++) md_v_r[k] <= md_v_r[k-1];
      out_valid_r <= md_v_r[LANE_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0] <= pm_r;
      for (int k = 1; k <= LANE_LAT; k++) md_r[k] <= md_r[k-1];
      out_zero_r <= md_r[LANE_LAT].zero;
      if (md_r[LANE_LAT].zero) begin
        out_x_r <= '0;
        out_y_r <= '0;
        out_z_r <= '0;
      end else begin
        out_x_r <= md_r[LANE_LAT].neg_a ? -OUT_W'(na) : OUT_W'(na);
        out_y_r <= md_r[LANE_LAT].neg_b ? -OUT_W'(nb) : OUT_W'(nb);
        out_z_r <= md_r[LANE_LAT].neg_c ? -OUT_W'(nc) : OUT_W'(nc);
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.dir_x = out_x_r;
  assign out_ch.dir_y = out_y_r;
  assign out_ch.dir_z = out_z_r;

  assign abs_x = out_x_r[OUT_W-1] ? -out_x_r : out_x_r;
  assign abs_y = out_y_r[OUT_W-1] ? -out_y_r : out_y_r;
  assign abs_z = out_z_r[OUT_W-1] ? -out_z_r : out_z_r;

  `ASSERT_IMPLY(a_zero_face, out_valid_r && out_zero_r,
    out_x_r == '0 && out_y_r == '0 && out_z_r == '0, "zero face gave a nonzero vector")
  `ASSERT_IMPLY(a_range, out_valid_r,
    abs_x <= OUT_W'(ONE_MAG) && abs_y <= OUT_W'(ONE_MAG) && abs_z <= OUT_W'(ONE_MAG),
    "direction component above one")
  `ASSERT_IMPLY(a_dominant, out_valid_r && !out_zero_r,
    abs_x >= OUT_W'(DOM_MIN) || abs_y >= OUT_W'(DOM_MIN) || abs_z >= OUT_W'(DOM_MIN),
    "no dominant axis in a face direction")
  `ASSERT_NEXT(a_stall_hold, !en,
    $stable(md_v_r[LANE_LAT]) && $stable(fd_v_r[COORD_LAT-1]) && $stable(p_v_r),
    "pipeline moved during a stall")

endmodule

>>> sim/ctdu_direction_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctdu_direction_checker
// Watches both channels of the cube map texel to direction unit, works out the
// direction each texel transfer must produce and compares every result
// transfer against it, in order.
// ----------------------------------------------------------------------------
module ctdu_direction_checker
  import ctdu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ctdu_in_if                   in_mon,
  ctdu_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   dirs_waiting,
  output int                   dirs_seen
);

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } dir_vec_t;

  dir_vec_t         dir_fifo[$];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  function automatic longint signed face_coord_q(longint unsigned pos,
                                                 longint unsigned size);
    longint unsigned twice;
    longint unsigned mag;
    longint unsigned q;
    bit neg;
    twice = 2 * pos + 1;
    neg = twice < size;
    mag = neg ? size - twice : twice - size;
    q = ((mag << FRAC_BITS) * 2 + size) / (2 * size);
    if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Rounded |a| * 16384 / sqrt(s) with the sign of a, found by bisection on squared bounds.
  function automatic logic signed [OUT_W-1:0] unit_component(longint signed a,
                                                             longint unsigned s);
    longint unsigned mag;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned n;
    longint unsigned t;
    logic [127:0] lim;
    logic [127:0] prod;
    mag = a < 0 ? longint'(-a) : longint'(a);
    lim = 128'(mag * mag) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      n = (lo + hi + 1) / 2;
      t = 2 * n - 1;
      prod = 128'(t * t) * 128'(s);
      if (prod <= lim) lo = n;
      else hi = n - 1;
    end
    if (lo > 16384) lo = 16384;
    return a < 0 ? -OUT_W'(lo) : OUT_W'(lo);
  endfunction

  function automatic dir_vec_t texel_direction(logic [COORD_BITS-1:0] col,
                                               logic [COORD_BITS-1:0] row,
                                               logic [FACE_W-1:0] face);
    longint unsigned w;
    longint unsigned h;
    longint unsigned s;
    longint signed one;
    longint signed u;
    longint signed v;
    longint signed a;
    longint signed b;
    longint signed c;
    dir_vec_t d;
    w = (width_reg == 0) ? 1 : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    one = 64'sd1 <<< FRAC_BITS;
    u = face_coord_q(col, w);
    v = -face_coord_q(row, h);
    d = '0;
    case (face)
      FACE_POS_X: begin a = one;  b = v;    c = -u;   end
      FACE_NEG_X: begin a = -one; b = v;    c = u;    end
      FACE_POS_Y: begin a = u;    b = one;  c = -v;   end
      FACE_NEG_Y: begin a = u;    b = -one; c = v;    end
      FACE_POS_Z: begin a = u;    b = v;    c = one;  end
      FACE_NEG_Z: begin a = -u;   b = v;    c = -one; end
      default: return d;
    endcase
    s = a * a + b * b + c * c;
    d.x = unit_component(a, s);
    d.y = unit_component(b, s);
    d.z = unit_component(c, s);
    return d;
  endfunction

  assign dirs_waiting = dir_fifo.size();

  always @(posedge clk) begin
    dir_vec_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      width_reg  <= 1;
      height_reg <= 1;
      fail_count <= 0;
      dirs_seen  <= 0;
      dir_fifo.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FACE_WIDTH) width_reg <= cfg_data;
        else if (cfg_index == REG_FACE_HEIGHT) height_reg <= cfg_data;
      end
      if (out_mon.valid && out_mon.ready) begin
        dirs_seen <= dirs_seen + 1;
        if (dir_fifo.size() == 0) begin
          $display("%0t: result transfer with nothing expected (%0d,%0d,%0d)",
                   $time, out_mon.dir_x, out_mon.dir_y, out_mon.dir_z);
          errs++;
        end else begin
          want = dir_fifo.pop_front();
          if (want.x !== out_mon.dir_x) begin
            $display("%0t: dir_x expected %0d, got %0d", $time, want.x, out_mon.dir_x);
            errs++;
          end
          if (want.y !== out_mon.dir_y) begin
            $display("%0t: dir_y expected %0d, got %0d", $time, want.y, out_mon.dir_y);
            errs++;
          end
          if (want.z !== out_mon.dir_z) begin
            $display("%0t: dir_z expected %0d, got %0d", $time, want.z, out_mon.dir_z);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (in_mon.valid && in_mon.ready)
        dir_fifo.push_back(texel_direction(in_mon.texel_col, in_mon.texel_row,
                                           in_mon.face_index));
    end
  end

endmodule

>>> sim/tb_cubemap_texel_to_direction_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cubemap_texel_to_direction_unit
// Drives texel addresses through the unit under several face sizes, including
// the smallest, the largest and a zero size, with random gaps on both sides
// and a long output stall, and leaves checking to ctdu_direction_checker.
// ----------------------------------------------------------------------------
module tb_cubemap_texel_to_direction_unit;
  import ctdu_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  int                   fail_count;
  int                   dirs_waiting;
  int                   dirs_seen;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   hold_cycles;
  int                   hold_reqs;
  int                   hold_acks;
  int                   texels_sent;
  int                   eff_w;
  int                   eff_h;

  ctdu_in_if  in_ch ();
  ctdu_out_if out_ch ();

  cubemap_texel_to_direction_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ctdu_direction_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .dirs_waiting (dirs_waiting),
    .dirs_seen    (dirs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", dirs_waiting);
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles  <= 0;
      hold_acks    <= 0;
      out_ch.ready <= 1'b0;
    end else if (hold_acks != hold_reqs) begin
      hold_acks    <= hold_reqs;
      hold_cycles  <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_texel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                            logic [FACE_W-1:0] face);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.texel_col  <= col;
    in_ch.texel_row  <= row;
    in_ch.face_index <= face;
    do @(posedge clk); while (!in_ch.ready);
    texels_sent++;
  endtask

  // The sender stops until every direction has come back, then the sizes change.
  task automatic set_face_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (dirs_waiting != 0);
    repeat (80) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FACE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FACE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_w = (w == '0) ? 1 : int'(w);
    eff_h = (h == '0) ? 1 : int'(h);
  endtask

  task automatic random_texels(int count, bit with_hold);
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [FACE_W-1:0]     face;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_reqs++;
      if ($urandom_range(9) == 0) begin
        col = COORD_BITS'($urandom);
        row = COORD_BITS'($urandom);
      end else begin
        col = COORD_BITS'($urandom_range(eff_w > 16384 ? 16383 : eff_w - 1));
        row = COORD_BITS'($urandom_range(eff_h > 16384 ? 16383 : eff_h - 1));
      end
      face = ($urandom_range(9) == 0) ? FACE_W'($urandom_range(7, 6))
                                      : FACE_W'($urandom_range(5));
      send_texel(col, row, face);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_FACE_WIDTH;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.texel_col  <= '0;
    in_ch.texel_row  <= '0;
    in_ch.face_index <= '0;
    hold_reqs        = 0;
    send_idle_pct    = 20;
    recv_idle_pct    = 53;
    texels_sent      = 0;
    eff_w            = 1;
    eff_h            = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int f = 0; f < 8; f++) send_texel(0, 0, FACE_W'(f));
    send_texel('1, '1, FACE_POS_X);
    send_texel('1, 0, FACE_POS_Z);
    set_face_size(16384, 16384);
    for (int f = 0; f < 8; f++) send_texel(0, '1, FACE_W'(f));
    send_texel('1, 0, FACE_NEG_Y);
    send_texel(8191, 8192, FACE_POS_Z);
    set_face_size(0, 0);
    send_texel(0, 0, FACE_NEG_Z);
    send_texel(5, 9, FACE_POS_Y);

    set_face_size(7, 3);
    random_texels(300, 1'b1);
    set_face_size(1, 16384);
    random_texels(250, 1'b0);
    send_idle_pct = 53;
    recv_idle_pct = 20;
    set_face_size(16384, 1);
    random_texels(250, 1'b0);
    set_face_size(256, 512);
    random_texels(350, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_face_size(3, 1000);
    random_texels(350, 1'b0);
    set_face_size(16384, 16384);
    random_texels(400, 1'b0);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (dirs_waiting != 0);
    repeat (80) @(posedge clk);
    $display("Sent %0d texel addresses over eight face sizes, all six faces and",
             texels_sent);
    $display("invalid faces; %0d directions checked.", dirs_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
